>>> hdl/qte_pkg.sv
package qte_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_DEF   = 16;
  localparam int TABLE_LEN        = 24;
  localparam int ZFRAC            = 30;
  localparam int DEG_K_FRAC       = 24;
  localparam int QW               = 16;
  localparam int XW               = 36;
  localparam int ZW               = 34;
  localparam int OUT_W            = 26;
  localparam int ISQ_STAGES       = 32;
  localparam int LH_W             = 33;
  localparam int SQ_IN_W          = 2 * ISQ_STAGES;
  localparam int SPLIT            = 17;
  localparam int FULL_W           = 66;

  localparam logic signed [ZW-1:0] HALF_PI_Z = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Z      = 34'sd3373259426;
  localparam logic signed [30:0]   DEG_K     = 31'sd961263669;

  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  typedef struct packed {
    logic signed [XW-1:0] yx;
    logic signed [XW-1:0] yy;
    logic signed [XW-1:0] rx;
    logic signed [XW-1:0] ry;
    logic signed [XW-1:0] ph;
    logic                 zero;
    logic                 sat;
  } carry_t;

  typedef struct packed {
    logic zero;
    logic sat;
    logic pneg;
  } flags_t;

endpackage

>>> hdl/qte_if.sv
interface qte_quat_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  quat_real;
  logic signed [15:0]  quat_i;
  logic signed [15:0]  quat_j;
  logic signed [15:0]  quat_k;
  modport source (output valid, quat_real, quat_i, quat_j, quat_k, input ready);
  modport sink   (input valid, quat_real, quat_i, quat_j, quat_k, output ready);
endinterface

interface qte_angle_if;
  logic                valid;
  logic                ready;
  logic signed [25:0]  yaw_angle;
  logic signed [25:0]  pitch_angle;
  logic signed [25:0]  roll_angle;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

>>> hdl/quaternion_to_euler_angles_top.sv
// Quaternion to ZYX Euler angles (yaw, pitch, roll).
// Channel quat takes one word of four signed Q1.14 components; channel
// angles gives one word of three 26-bit signed angles with ANGLE_FRAC_BITS
// fraction bits, in radians, or degrees while angle_unit is set.
// cfg_we/cfg_data write angle_unit; write it only while the block is idle.
// The pipeline is three product/sum stages, one 33x33 multiply, a
// 32-stage square root for the pitch cosine, one pre-rotation plus
// CORDIC_STEPS CORDIC stages, and two scaling stages. One word is
// accepted every cycle unless the receiver stalls.
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls, quat.ready drops and every stage holds.
// Reset clears all valid bits and sets angle_unit to radians.
module quaternion_to_euler_angles_top #(
  parameter int CORDIC_STEPS    = qte_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  qte_quat_if.sink    quat,
  qte_angle_if.source angles
);
  import qte_pkg::*;

  localparam int SH_RAD = ZFRAC - ANGLE_FRAC_BITS;
  localparam int SH_DEG = ZFRAC + DEG_K_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [FULL_W-1:0] RND_RAD = FULL_W'(1) <<< (SH_RAD - 1);
  localparam logic signed [FULL_W-1:0] RND_DEG = FULL_W'(1) <<< (SH_DEG - 1);
  localparam logic signed [FULL_W-1:0] OUT_MAX = (FULL_W'(1) <<< (OUT_W - 1)) - 1;
  localparam logic signed [FULL_W-1:0] OUT_MIN = -(FULL_W'(1) <<< (OUT_W - 1));

  logic en;
  logic angle_unit;

  logic v1, v2, v3, vo1, vo2;
  logic [ISQ_STAGES:0]   vc;
  logic [CORDIC_STEPS:0] vk;

  logic signed [2*QW-1:0] rr, ii, jj, kk, ij, kr, jk, ir, ik, jr;
  logic signed [XW-1:0]   n2, yx2, yy2, rx2, ry2, ph2;
  logic [LH_W-1:0]        lo3, hi3;
  carry_t                 carry3;
  logic [SQ_IN_W-1:0]     prod4;
  carry_t                 c_q [ISQ_STAGES+1];
  logic [ISQ_STAGES-1:0]  root;
  flags_t                 fk [CORDIC_STEPS+1];
  logic signed [ZW-1:0]   z_c [3];
  logic signed [ZW-1:0]   z_sel [3];
  logic signed [ZW-1:0]   zq [3];
  logic signed [47:0]     phi [3];
  logic signed [48:0]     plo [3];
  logic                   unit_q;
  logic signed [FULL_W-1:0] full [3];
  logic signed [FULL_W-1:0] rnd [3];
  logic signed [OUT_W-1:0]  res [3];

  assign en         = !vo2 || angles.ready;
  assign quat.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_unit <= 1'b0;
    end else if (cfg_we) begin
      angle_unit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      vc  <= '0;
      vk  <= '0;
      vo1 <= 1'b0;
      vo2 <= 1'b0;
    end else if (en) begin
      v1  <= quat.valid;
      v2  <= v1;
      v3  <= v2;
      vc  <= {vc[ISQ_STAGES-1:0], v3};
      vk  <= {vk[CORDIC_STEPS-1:0], vc[ISQ_STAGES]};
      vo1 <= vk[CORDIC_STEPS];
      vo2 <= vo1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr <= quat.quat_real * quat.quat_real;
      ii <= quat.quat_i * quat.quat_i;
      jj <= quat.quat_j * quat.quat_j;
      kk <= quat.quat_k * quat.quat_k;
      ij <= quat.quat_i * quat.quat_j;
      kr <= quat.quat_k * quat.quat_real;
      jk <= quat.quat_j * quat.quat_k;
      ir <= quat.quat_i * quat.quat_real;
      ik <= quat.quat_i * quat.quat_k;
      jr <= quat.quat_j * quat.quat_real;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2  <= XW'(ii) + XW'(jj) + XW'(kk) + XW'(rr);
      yx2 <= XW'(ii) - XW'(jj) - XW'(kk) + XW'(rr);
      yy2 <= (XW'(ij) + XW'(kr)) <<< 1;
      rx2 <= XW'(kk) + XW'(rr) - XW'(ii) - XW'(jj);
      ry2 <= (XW'(jk) + XW'(ir)) <<< 1;
      ph2 <= XW'(jr) - XW'(ik);
    end
  end

  logic signed [XW-1:0] mag2;
  logic signed [XW-1:0] dif2, sum2;
  assign mag2 = (ph2 < 0) ? (-ph2) <<< 1 : ph2 <<< 1;
  assign dif2 = n2 - mag2;
  assign sum2 = n2 + mag2;

  always_ff @(posedge clk) begin
    if (en) begin
      lo3         <= dif2[LH_W:1];
      hi3         <= sum2[LH_W:1];
      carry3.yx   <= yx2;
      carry3.yy   <= yy2;
      carry3.rx   <= rx2;
      carry3.ry   <= ry2;
      carry3.ph   <= ph2;
      carry3.zero <= (n2 == '0);
      carry3.sat  <= (mag2 >= n2);
    end
  end

  logic [2*LH_W-1:0] prod3;
  assign prod3 = lo3 * hi3;

  always_ff @(posedge clk) begin
    if (en) begin
      prod4  <= prod3[SQ_IN_W-1:0];
      c_q[0] <= carry3;
    end
  end

  for (genvar d = 1; d <= ISQ_STAGES; d++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en) begin
        c_q[d] <= c_q[d-1];
      end
    end
  end

  qte_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .v_in (prod4),
    .root (root)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk   (clk),
    .en    (en),
    .x_in  (c_q[ISQ_STAGES].yx),
    .y_in  (c_q[ISQ_STAGES].yy),
    .z_out (z_c[0])
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk   (clk),
    .en    (en),
    .x_in  (XW'(root)),
    .y_in  (c_q[ISQ_STAGES].ph),
    .z_out (z_c[1])
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk   (clk),
    .en    (en),
    .x_in  (c_q[ISQ_STAGES].rx),
    .y_in  (c_q[ISQ_STAGES].ry),
    .z_out (z_c[2])
  );

  always_ff @(posedge clk) begin
    if (en) begin
      fk[0].zero <= c_q[ISQ_STAGES].zero;
      fk[0].sat  <= c_q[ISQ_STAGES].sat;
      fk[0].pneg <= c_q[ISQ_STAGES].ph[XW-1];
    end
  end

  for (genvar s = 1; s <= CORDIC_STEPS; s++) begin : g_flags
    always_ff @(posedge clk) begin
      if (en) begin
        fk[s] <= fk[s-1];
      end
    end
  end

  always_comb begin
    z_sel[0] = fk[CORDIC_STEPS].zero ? '0 : z_c[0];
    z_sel[2] = fk[CORDIC_STEPS].zero ? '0 : z_c[2];
    priority if (fk[CORDIC_STEPS].zero) begin
      z_sel[1] = '0;
    end else if (fk[CORDIC_STEPS].sat) begin
      z_sel[1] = fk[CORDIC_STEPS].pneg ? -HALF_PI_Z : HALF_PI_Z;
    end else begin
      z_sel[1] = z_c[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_q <= angle_unit;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_scale
    logic signed [ZW-SPLIT-1:0] zh;
    logic signed [SPLIT:0]      zl;
    assign zh = z_sel[a][ZW-1:SPLIT];
    assign zl = {1'b0, z_sel[a][SPLIT-1:0]};

    always_ff @(posedge clk) begin
      if (en) begin
        zq[a]  <= z_sel[a];
        phi[a] <= zh * DEG_K;
        plo[a] <= zl * DEG_K;
      end
    end

    always_comb begin
      if (unit_q) begin
        full[a] = (FULL_W'(phi[a]) <<< SPLIT) + FULL_W'(plo[a]);
        rnd[a]  = (full[a] + RND_DEG) >>> SH_DEG;
      end else begin
        full[a] = FULL_W'(zq[a]);
        rnd[a]  = (full[a] + RND_RAD) >>> SH_RAD;
      end
      priority if (rnd[a] > OUT_MAX) begin
        res[a] = OUT_MAX[OUT_W-1:0];
      end else if (rnd[a] < OUT_MIN) begin
        res[a] = OUT_MIN[OUT_W-1:0];
      end else begin
        res[a] = rnd[a][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angles.yaw_angle   <= res[0];
      angles.pitch_angle <= res[1];
      angles.roll_angle  <= res[2];
    end
  end

  assign angles.valid = vo2;
endmodule

>>> hdl/qte_isqrt.sv
module qte_isqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [qte_pkg::SQ_IN_W-1:0]    v_in,
  output logic [qte_pkg::ISQ_STAGES-1:0] root
);
  import qte_pkg::*;

  localparam int RW = ISQ_STAGES + 2;

  logic [RW-1:0]         r_q   [ISQ_STAGES];
  logic [ISQ_STAGES-1:0] q_q   [ISQ_STAGES];
  logic [SQ_IN_W-1:0]    v_q   [ISQ_STAGES];
  logic [RW-1:0]         r_prv [ISQ_STAGES];
  logic [ISQ_STAGES-1:0] q_prv [ISQ_STAGES];
  logic [SQ_IN_W-1:0]    v_prv [ISQ_STAGES];

  for (genvar b = 0; b < ISQ_STAGES; b++) begin : g_stage
    logic [RW+1:0] rs;
    logic [RW+1:0] t;
    if (b == 0) begin : g_first
      assign r_prv[b] = '0;
      assign q_prv[b] = '0;
      assign v_prv[b] = v_in;
    end else begin : g_next
      assign r_prv[b] = r_q[b-1];
      assign q_prv[b] = q_q[b-1];
      assign v_prv[b] = v_q[b-1];
    end
    assign rs = {r_prv[b], v_prv[b][SQ_IN_W-1 -: 2]};
    assign t  = {2'b00, q_prv[b], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        v_q[b] <= {v_prv[b][SQ_IN_W-3:0], 2'b00};
        if (rs >= t) begin
          r_q[b] <= RW'(rs - t);
          q_q[b] <= {q_prv[b][ISQ_STAGES-2:0], 1'b1};
        end else begin
          r_q[b] <= RW'(rs);
          q_q[b] <= {q_prv[b][ISQ_STAGES-2:0], 1'b0};
        end
      end
    end
  end

  assign root = q_q[ISQ_STAGES-1];
endmodule

>>> hdl/qte_cordic.sv
module qte_cordic #(
  parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qte_pkg::XW-1:0] x_in,
  input  logic signed [qte_pkg::XW-1:0] y_in,
  output logic signed [qte_pkg::ZW-1:0] z_out
);
  import qte_pkg::*;

  logic signed [XW-1:0] x_q  [STEPS+1];
  logic signed [XW-1:0] y_q  [STEPS+1];
  logic signed [ZW-1:0] z_q  [STEPS+1];
  logic                 zz_q [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      zz_q[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x_q[0] <= -x_in;
        y_q[0] <= -y_in;
        z_q[0] <= (y_in >= 0) ? PI_Z : -PI_Z;
      end else begin
        x_q[0] <= x_in;
        y_q[0] <= y_in;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar s = 1; s <= STEPS; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zz_q[s] <= zz_q[s-1];
        if (y_q[s-1] >= 0) begin
          x_q[s] <= x_q[s-1] + (y_q[s-1] >>> (s-1));
          y_q[s] <= y_q[s-1] - (x_q[s-1] >>> (s-1));
          z_q[s] <= z_q[s-1] + ATAN_TAB[s-1];
        end else begin
          x_q[s] <= x_q[s-1] - (y_q[s-1] >>> (s-1));
          y_q[s] <= y_q[s-1] + (x_q[s-1] >>> (s-1));
          z_q[s] <= z_q[s-1] - ATAN_TAB[s-1];
        end
      end
    end
  end

  assign z_out = zz_q[STEPS] ? '0 : z_q[STEPS];
endmodule

>>> hdl/qte_checker.sv
module qte_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [25:0] yaw_angle
);

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(yaw_angle))
    else $error("stalled output word changed");

  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (quat.ready),
  .out_valid (angles.valid),
  .out_ready (angles.ready),
  .yaw_angle (angles.yaw_angle)
);

>>> dv/tb_quaternion_to_euler_angles_top.sv
module tb_quaternion_to_euler_angles_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qte_pkg::*;

  localparam int LATENCY = CORDIC_STEPS_DEF + 39;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [25:0] yaw;
    logic signed [25:0] pitch;
    logic signed [25:0] roll;
  } angles_t;

  class angle_scoreboard;
    angles_t pending[$];
    int errors;
    int checked;
    bit unit_deg;

    function automatic longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    function automatic longint cordic_angle(longint y, longint x);
      longint z;
      longint dx;
      longint dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? longint'(PI_Z) : -longint'(PI_Z);
        x = -x;
        y = -y;
      end
      for (int s = 0; s < CORDIC_STEPS_DEF && s < TABLE_LEN; s++) begin
        dx = floor_shr(y, s);
        dy = floor_shr(x, s);
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'(ATAN_TAB[s]);
        end else begin
          x -= dx; y += dy; z -= longint'(ATAN_TAB[s]);
        end
      end
      return z;
    endfunction

    function automatic longint int_root(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return longint'(res);
    endfunction

    function automatic logic signed [25:0] scale_angle(longint z);
      longint v;
      longint lim;
      int sh;
      lim = longint'(1) << (OUT_W - 1);
      if (unit_deg) begin
        v = z * longint'(DEG_K);
        sh = ZFRAC + DEG_K_FRAC - ANGLE_FRAC_DEF;
      end else begin
        v = z;
        sh = ZFRAC - ANGLE_FRAC_DEF;
      end
      v = (v + (longint'(1) << (sh - 1))) >>> sh;
      if (v > lim - 1) v = lim - 1;
      if (v < -lim) v = -lim;
      return v[25:0];
    endfunction

    function void note_quat(logic signed [15:0] qr, logic signed [15:0] qi,
                            logic signed [15:0] qj, logic signed [15:0] qk);
      longint r, i, j, k, n, a, mag, c, pz;
      longint unsigned lo, hi;
      angles_t e;
      r = qr; i = qi; j = qj; k = qk;
      n = i*i + j*j + k*k + r*r;
      if (n == 0) begin
        e.yaw = 0; e.pitch = 0; e.roll = 0;
      end else begin
        e.yaw = scale_angle(cordic_angle(2*(i*j + k*r), i*i - j*j - k*k + r*r));
        e.roll = scale_angle(cordic_angle(2*(j*k + i*r), -i*i - j*j + k*k + r*r));
        a = -2 * (i*k - j*r);
        mag = (a < 0) ? -a : a;
        if (mag >= n) begin
          pz = (a < 0) ? -longint'(HALF_PI_Z) : longint'(HALF_PI_Z);
        end else begin
          lo = longint'(n - mag) >> 1;
          hi = longint'(n + mag) >> 1;
          c = int_root(lo * hi);
          pz = cordic_angle(a / 2, c);
        end
        e.pitch = scale_angle(pz);
      end
      pending.push_back(e);
    endfunction

    function void check_angles(logic signed [25:0] yaw, logic signed [25:0] pitch,
                               logic signed [25:0] roll);
      angles_t e;
      if (pending.size() == 0) begin
        $error("unexpected angle word yaw=%0d pitch=%0d roll=%0d", yaw, pitch, roll);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (yaw !== e.yaw) begin
        $error("yaw_angle expected %0d actual %0d", e.yaw, yaw); errors++;
      end
      if (pitch !== e.pitch) begin
        $error("pitch_angle expected %0d actual %0d", e.pitch, pitch); errors++;
      end
      if (roll !== e.roll) begin
        $error("roll_angle expected %0d actual %0d", e.roll, roll); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_data;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;
  bit timed_out;
  int sent;

  qte_quat_if quat ();
  qte_angle_if angles ();
  angle_scoreboard board;

  quaternion_to_euler_angles_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .quat(quat.sink), .angles(angles.source)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (angles.valid && angles.ready)
        board.check_angles(angles.yaw_angle, angles.pitch_angle, angles.roll_angle);
      if ((quat.valid && quat.ready) || (angles.valid && angles.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    angles.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_quat(logic signed [15:0] qr, logic signed [15:0] qi,
                           logic signed [15:0] qj, logic signed [15:0] qk);
    while ($urandom_range(99) < send_idle_pct) begin
      quat.valid <= 1'b0;
      @(negedge clk);
    end
    quat.valid <= 1'b1;
    quat.quat_real <= qr;
    quat.quat_i <= qi;
    quat.quat_j <= qj;
    quat.quat_k <= qk;
    do @(posedge clk); while (!quat.ready);
    board.note_quat(qr, qi, qj, qk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    quat.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_unit(bit deg);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= deg;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.unit_deg = deg;
  endtask

  task automatic send_random(int count);
    logic signed [15:0] q[4];
    int shape;
    for (int n = 0; n < count; n++) begin
      shape = $urandom_range(9);
      for (int c = 0; c < 4; c++) q[c] = 16'($urandom);
      if (shape < 4) begin
        for (int c = 0; c < 4; c++) q[c] = $signed(q[c]) >>> 1;
      end else if (shape == 4) begin
        for (int c = 0; c < 4; c++) q[c] = $signed(q[c]) >>> $urandom_range(15, 4);
      end else if (shape == 5) begin
        q[$urandom_range(3)] = '0;
        q[$urandom_range(3)] = '0;
      end else if (shape == 6) begin
        q[2] = q[0];
        q[3] = -q[1];
      end
      send_quat(q[0], q[1], q[2], q[3]);
    end
  endtask

  task automatic send_directed();
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(11585, 11585, 11585, 11585);
    send_quat(0, 16384, 16384, 0);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(-32768, 0, 0, 0);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(1, 0, 0, 0);
    send_quat(0, 0, 0, -1);
    send_quat(8192, 8192, 8192, -8192);
    send_quat(100, -3, 7, 1);
    send_quat(16384, 0, 0, 1);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    quat.valid = 1'b0;
    quat.quat_real = '0;
    quat.quat_i = '0;
    quat.quat_j = '0;
    quat.quat_k = '0;
    angles.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_directed();
    write_unit(1'b1);
    send_directed();
    send_random(250);
    send_idle_pct = 70;
    send_random(100);
    drain();
    send_random(100);
    write_unit(1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 70;
    send_random(250);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    send_random(200);
    write_unit(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(200);
    drain();

    $display("Sent %0d quaternions, checked %0d angle words in radians and degrees,",
             sent, board.checked);
    $display("with extremes, zero input, saturated pitch and random stall patterns.");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("** quaternion_to_euler_angles_top: PASSED **");
    else
      $display("** quaternion_to_euler_angles_top: FAILED **");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog expired with %0d words pending", board.pending.size());
    $display("** quaternion_to_euler_angles_top: FAILED **");
    $finish;
  end
endmodule
